>>> rtl/setup_pin_from_mac_hash_defines.svh
// Assertion macros shared by the checker.
`ifndef SETUP_PIN_FROM_MAC_HASH_DEFINES_SVH
`define SETUP_PIN_FROM_MAC_HASH_DEFINES_SVH

// Check a condition at every clock edge outside reset.
`define SPH_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Check that a consequent holds in the cycle where the antecedent holds.
`define SPH_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

>>> rtl/sph_pkg.sv
`timescale 1ns / 1ps

package sph_pkg;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
        logic [31:0] e;
        logic [31:0] f;
        logic [31:0] g;
        logic [31:0] h;
    } hash_state_t;

    // Sliding window of sixteen schedule words, word 0 is used this round.
    typedef logic [15:0][31:0] sched_t;

    typedef struct packed {
        logic [26:0] pin;
        logic [27:0] bin;
        logic [31:0] bcd;
    } bcd_item_t;

    localparam int unsigned NUM_ROUNDS = 64;
    localparam int unsigned MAC_BYTES  = 6;
    localparam int unsigned BCD_STAGES = 7;

    localparam logic [1:0] REG_SALT_FIRST  = 2'd0;
    localparam logic [1:0] REG_SALT_LAST   = 2'd1;
    localparam logic [1:0] REG_SALT_LENGTH = 2'd2;

    localparam logic [26:0] PIN_MODULUS = 27'd100000000;
    // floor(2^58 / 100000000); quotient estimate is low by at most one
    localparam logic [31:0] PIN_RECIP  = 32'd2882303761;
    localparam int unsigned RECIP_SHIFT = 58;

    localparam hash_state_t INIT_H = '{
        a: 32'h6a09e667, b: 32'hbb67ae85, c: 32'h3c6ef372, d: 32'ha54ff53a,
        e: 32'h510e527f, f: 32'h9b05688c, g: 32'h1f83d9ab, h: 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

endpackage

>>> rtl/setup_pin_from_mac_hash.sv
`timescale 1ns / 1ps

// Setup PIN generator: hashes a 6-byte hardware address followed by a salt of
// up to MAX_SALT_BYTES bytes with SHA-256 (one padded block), takes the first
// digest word modulo 100000000 and returns the PIN in binary and as eight BCD
// digits. One transaction is taken in every clock cycle: busy is tied low and
// start may stay high. Each result appears on pin_value and pin_digits for a
// single cycle with result_valid high, after 1 padding stage, 64 round stages,
// 4 reduction stages and 7 BCD stages; results come out in order and the
// receiver must take them as they come. The round pipeline is fully unrolled.
// Program the salt over the APB port only while no transaction is in flight:
// salt_first_bytes at 0x00, salt_last_bytes at 0x08, salt_length at 0x10;
// lengths above MAX_SALT_BYTES saturate.
module setup_pin_from_mac_hash #(
    parameter int unsigned MAX_SALT_BYTES = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    input  logic        start,
    output logic        busy,
    input  logic [47:0] mac_address,
    output logic        result_valid,
    output logic [26:0] pin_value,
    output logic [31:0] pin_digits
);

    localparam logic [4:0] MaxSalt = 5'(MAX_SALT_BYTES);

    // Configuration registers
    logic [63:0] salt_first_reg;
    logic [63:0] salt_last_reg;
    logic [4:0]  salt_size_reg;
    logic        cfg_write;

    assign pready    = 1'b1;
    assign busy      = 1'b0;
    assign cfg_write = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            salt_first_reg <= '0;
            salt_last_reg  <= '0;
            salt_size_reg  <= '0;
        end
        else if (cfg_write)
        begin
            case (paddr[4:3])
                sph_pkg::REG_SALT_FIRST:  salt_first_reg <= pwdata;
                sph_pkg::REG_SALT_LAST:   salt_last_reg  <= pwdata;
                sph_pkg::REG_SALT_LENGTH: salt_size_reg  <= pwdata[4:0];
                default:                  ; // drop writes beyond the map
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:3])
            sph_pkg::REG_SALT_FIRST:  prdata = salt_first_reg;
            sph_pkg::REG_SALT_LAST:   prdata = salt_last_reg;
            sph_pkg::REG_SALT_LENGTH: prdata = {59'b0, salt_size_reg};
            default:                  prdata = '0;
        endcase
    end

    // Padding stage: lay out address, salt, end marker and bit length
    logic [4:0]       salt_size_eff;
    logic [4:0]       msg_len;
    logic [127:0]     salt_all;
    logic [511:0]     blk;
    logic             pad_valid_reg;
    sph_pkg::sched_t  pad_sched_reg;
    sph_pkg::sched_t  pad_sched_next;

    always_comb
    begin
        salt_size_eff = (salt_size_reg > MaxSalt) ? MaxSalt : salt_size_reg;
        msg_len       = 5'(sph_pkg::MAC_BYTES) + salt_size_eff;
        salt_all      = {salt_first_reg, salt_last_reg};
        for (int i = 0; i < 64; i++)
        begin
            if (i < 6)
            begin
                blk[511 - 8*i -: 8] = mac_address[47 - 8*i -: 8];
            end
            else if ((i - 6) < 16 && (i - 6) < int'(salt_size_eff))
            begin
                blk[511 - 8*i -: 8] = salt_all[127 - 8*(i - 6) -: 8];
            end
            else if ((i - 6) == int'(salt_size_eff))
            begin
                blk[511 - 8*i -: 8] = 8'h80;
            end
            else
            begin
                blk[511 - 8*i -: 8] = 8'h00;
            end
        end
        // message length in bits never exceeds one byte
        blk[7:0] = {msg_len, 3'b000};
        for (int k = 0; k < 16; k++)
        begin
            pad_sched_next[k] = blk[511 - 32*k -: 32];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pad_valid_reg <= 1'b0;
        end
        else
        begin
            pad_valid_reg <= start & ~busy;
        end
    end

    always_ff @(posedge clk)
    begin
        pad_sched_reg <= pad_sched_next;
    end

    // Round pipeline: one compression round per stage
    logic                 rnd_valid [sph_pkg::NUM_ROUNDS + 1];
    sph_pkg::hash_state_t rnd_state [sph_pkg::NUM_ROUNDS + 1];
    sph_pkg::sched_t      rnd_sched [sph_pkg::NUM_ROUNDS + 1];

    assign rnd_valid[0] = pad_valid_reg;
    assign rnd_state[0] = sph_pkg::INIT_H;
    assign rnd_sched[0] = pad_sched_reg;

    for (genvar r = 0; r < sph_pkg::NUM_ROUNDS; r++)
    begin : g_round
        sph_round #(
            .ROUND_IDX (r)
        ) u_round (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (rnd_valid[r]),
            .in_state  (rnd_state[r]),
            .in_sched  (rnd_sched[r]),
            .out_valid (rnd_valid[r + 1]),
            .out_state (rnd_state[r + 1]),
            .out_sched (rnd_sched[r + 1])
        );
    end

    // Final add and reduction modulo one hundred million
    logic        red_valid;
    logic [26:0] red_pin;

    sph_reduce u_reduce (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rnd_valid[sph_pkg::NUM_ROUNDS]),
        .in_a      (rnd_state[sph_pkg::NUM_ROUNDS].a),
        .out_valid (red_valid),
        .out_pin   (red_pin)
    );

    // Binary to BCD, four bits per stage; a leading zero pads to 28 bits
    logic               bcd_valid [sph_pkg::BCD_STAGES + 1];
    sph_pkg::bcd_item_t bcd_item  [sph_pkg::BCD_STAGES + 1];

    assign bcd_valid[0]    = red_valid;
    assign bcd_item[0].pin = red_pin;
    assign bcd_item[0].bin = {1'b0, red_pin};
    assign bcd_item[0].bcd = '0;

    for (genvar s = 0; s < sph_pkg::BCD_STAGES; s++)
    begin : g_bcd
        sph_bcd_stage u_bcd (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (bcd_valid[s]),
            .in_item   (bcd_item[s]),
            .out_valid (bcd_valid[s + 1]),
            .out_item  (bcd_item[s + 1])
        );
    end

    assign result_valid = bcd_valid[sph_pkg::BCD_STAGES];
    assign pin_value    = bcd_item[sph_pkg::BCD_STAGES].pin;
    assign pin_digits   = bcd_item[sph_pkg::BCD_STAGES].bcd;

endmodule

>>> rtl/sph_round.sv
`timescale 1ns / 1ps

module sph_round #(
    parameter int unsigned ROUND_IDX = 0
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  sph_pkg::hash_state_t in_state,
    input  sph_pkg::sched_t      in_sched,
    output logic                 out_valid,
    output sph_pkg::hash_state_t out_state,
    output sph_pkg::sched_t      out_sched
);

    localparam logic [31:0] RoundK = sph_pkg::ROUND_K[ROUND_IDX[5:0]];

    logic                 valid_reg;
    sph_pkg::hash_state_t state_reg;
    sph_pkg::hash_state_t state_next;
    sph_pkg::sched_t      sched_reg;
    sph_pkg::sched_t      sched_next;

    logic [31:0] t1;
    logic [31:0] t2;

    always_comb
    begin
        t1 = in_state.h + sph_pkg::big_sigma1(in_state.e)
           + ((in_state.e & in_state.f) ^ (~in_state.e & in_state.g))
           + RoundK + in_sched[0];
        t2 = sph_pkg::big_sigma0(in_state.a)
           + ((in_state.a & in_state.b) ^ (in_state.a & in_state.c)
              ^ (in_state.b & in_state.c));
        state_next.a = t1 + t2;
        state_next.b = in_state.a;
        state_next.c = in_state.b;
        state_next.d = in_state.c;
        state_next.e = in_state.d + t1;
        state_next.f = in_state.e;
        state_next.g = in_state.f;
        state_next.h = in_state.g;
        // advance the schedule window by one word
        for (int i = 0; i < 15; i++)
        begin
            sched_next[i] = in_sched[i + 1];
        end
        sched_next[15] = sph_pkg::small_sigma1(in_sched[14]) + in_sched[9]
                       + sph_pkg::small_sigma0(in_sched[1]) + in_sched[0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        state_reg <= state_next;
        sched_reg <= sched_next;
    end

    assign out_valid = valid_reg;
    assign out_state = state_reg;
    assign out_sched = sched_reg;

endmodule

>>> rtl/sph_reduce.sv
`timescale 1ns / 1ps

module sph_reduce (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic [31:0] in_a,
    output logic        out_valid,
    output logic [26:0] out_pin
);

    logic [3:0]  valid_reg;
    logic [31:0] sum_reg;
    logic [31:0] sum2_reg;
    logic [63:0] prod_reg;
    logic [63:0] prod_next;
    logic [27:0] rem_reg;
    logic [27:0] rem_next;
    logic [26:0] pin_reg;
    logic [26:0] pin_next;
    logic [5:0]  quot;
    logic [32:0] qm;
    logic [32:0] diff;

    always_comb
    begin
        prod_next = 64'(sum_reg) * 64'(sph_pkg::PIN_RECIP);
        quot      = prod_reg[sph_pkg::RECIP_SHIFT +: 6];
        qm        = 33'(quot) * 33'(sph_pkg::PIN_MODULUS);
        diff      = {1'b0, sum2_reg} - qm;
        rem_next  = diff[27:0];
        // the estimate is low by at most one modulus
        if (rem_reg >= 28'(sph_pkg::PIN_MODULUS))
        begin
            pin_next = 27'(rem_reg - 28'(sph_pkg::PIN_MODULUS));
        end
        else
        begin
            pin_next = rem_reg[26:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg  <= sph_pkg::INIT_H.a + in_a;
        sum2_reg <= sum_reg;
        prod_reg <= prod_next;
        rem_reg  <= rem_next;
        pin_reg  <= pin_next;
    end

    assign out_valid = valid_reg[3];
    assign out_pin   = pin_reg;

endmodule

>>> rtl/sph_bcd_stage.sv
`timescale 1ns / 1ps

module sph_bcd_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  sph_pkg::bcd_item_t in_item,
    output logic               out_valid,
    output sph_pkg::bcd_item_t out_item
);

    logic               valid_reg;
    sph_pkg::bcd_item_t item_reg;
    sph_pkg::bcd_item_t item_next;

    // four shift-and-add-3 steps per stage
    always_comb
    begin
        item_next = in_item;
        for (int s = 0; s < 4; s++)
        begin
            for (int d = 0; d < 8; d++)
            begin
                if (item_next.bcd[4*d +: 4] >= 4'd5)
                begin
                    item_next.bcd[4*d +: 4] = item_next.bcd[4*d +: 4] + 4'd3;
                end
            end
            item_next.bcd = {item_next.bcd[30:0], item_next.bin[27]};
            item_next.bin = {item_next.bin[26:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

>>> rtl/sph_checker.sv
`timescale 1ns / 1ps
`include "setup_pin_from_mac_hash_defines.svh"

module sph_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        result_valid,
    input logic [26:0] pin_value,
    input logic [31:0] pin_digits
);

    logic digits_ok;

    always_comb
    begin
        digits_ok = 1'b1;
        for (int d = 0; d < 8; d++)
        begin
            if (pin_digits[4*d +: 4] > 4'd9)
            begin
                digits_ok = 1'b0;
            end
        end
    end

    `SPH_ASSERT_ALWAYS(a_never_busy, clk, rst_n, !busy, "busy raised")
    `SPH_ASSERT_IMPL(a_pin_range, clk, rst_n, result_valid, pin_value < 27'd100000000, "pin out of range")
    `SPH_ASSERT_IMPL(a_digits_bcd, clk, rst_n, result_valid, digits_ok, "digit above nine")
    `SPH_ASSERT_IMPL(a_start_taken, clk, rst_n, start, !busy, "start refused")

endmodule

bind setup_pin_from_mac_hash sph_checker u_sph_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .result_valid (result_valid),
    .pin_value    (pin_value),
    .pin_digits   (pin_digits)
);
